/* design/sdt_pkg.sv */
// sdt_pkg: shared types and constants for the subspace density test.
// No dependencies; imported by every module of the block.
`default_nettype none
package sdt_pkg;

	// squared-distance arithmetic
	localparam int ACC_W       = 38;              // per-candidate squared distance, Q8.30
	localparam int TOT_W       = 54;              // running sum of in-radius distances
	localparam int INV_W       = 32;              // reciprocal of squared radius, Q16.16
	localparam int PHI_W       = 32;              // density sum, Q16.16
	localparam int CNT_THR_W   = 16;
	localparam int NT_W        = 16;              // reported neighbour total
	localparam int TOT_SPLIT   = 30;              // total split point for the two products
	localparam int HI_W        = TOT_W - TOT_SPLIT;
	localparam int PROD_HI_W   = HI_W + INV_W;
	localparam int PROD_LO_W   = TOT_SPLIT + INV_W;
	localparam int TERM_W      = PROD_HI_W + 1;
	localparam int SQ_IN_W     = 19;              // widest magnitude that is squared
	localparam logic [63:0] SQ_SAT_LIM = 64'h7FFFF;

	// candidate queue
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// configuration register map
	localparam int REG_IDX_W  = 3;
	localparam int REG_ADDR_W = REG_IDX_W + 3;
	localparam int REG_DATA_W = 64;
	localparam logic [REG_IDX_W-1:0] REG_MODE      = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_RADIUS_SQ = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_INV_RAD   = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_BALL_THR  = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_COUNT_THR = 3'd4;

	// one closed candidate, front to back
	typedef struct packed {
		logic [ACC_W-1:0] dist_sq;
		logic             is_self;
		logic             last;
	} cand_rec_t;

	// settings seen by the back end
	typedef struct packed {
		logic                 rect_mode;
		logic [ACC_W-1:0]     radius_sq;
		logic [INV_W-1:0]     inv_radius_sq;
		logic [PHI_W-1:0]     ball_threshold;
		logic [CNT_THR_W-1:0] count_threshold;
	} back_cfg_t;

	typedef enum logic [2:0] {
		B_RUN,
		B_MUL,
		B_SUM,
		B_PHI,
		B_LOAD
	} back_state_t;

endpackage
`default_nettype wire

/* design/subspace_density_test.sv */
// subspace_density_test: top level; configuration registers and the stream ports.
// Depends on sdt_pkg, sdt_front, sdt_queue and sdt_back.
//
//  port group  dir  role                       beat contents
//  s_*         in   one dimension of one cand. tdata coords, tuser flags, tlast end of point
//  m_*         out  one decision per point     tdata dense flag, neighbour total, density sum
//  p*          in   register writes and reads  byte address 8*index, 64-bit data
//
// The front takes one beat per cycle as long as the candidate queue has room for
// every candidate that could close in its two-stage squaring pipeline.
// The back pops a closed candidate whenever the queue holds one, and at the end of a point it
// forms both partial products together, then their sum, the subtraction, and the output load.
// A result left untaken stalls only the back; the front keeps taking beats until
// the queue fills. Reset is asynchronous and needs no clearing pass.
`default_nettype none
module subspace_density_test #(
	parameter int COORD_BITS = 16,
	parameter int MAX_DIMS   = 64,
	parameter int COUNT_BITS = 16
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	// slave stream
	input  wire                                   s_tvalid,
	output logic                                  s_tready,
	// [COORD_BITS-1:0] point_coord, [2*COORD_BITS-1:COORD_BITS] cand_coord, rest zero
	input  wire [((2*COORD_BITS+7)/8)*8-1:0]      s_tdata,
	// [0] is_self, [1] last_dim
	input  wire [1:0]                             s_tuser,
	input  wire                                   s_tlast,   // last_candidate
	// master stream
	output logic                                  m_tvalid,
	input  wire                                   m_tready,
	// [0] dense flag, [16:1] neighbor_total, [48:17] density_sum, [55:49] zero
	output logic [55:0]                           m_tdata,
	// register port
	input  wire                                   psel,
	input  wire                                   penable,
	input  wire                                   pwrite,
	input  wire [sdt_pkg::REG_ADDR_W-1:0]         paddr,
	input  wire [sdt_pkg::REG_DATA_W-1:0]         pwdata,
	output logic [sdt_pkg::REG_DATA_W-1:0]        prdata,
	output logic                                  pready
);
	import sdt_pkg::*;

	logic                  rect_mode_q;
	logic [ACC_W-1:0]      radius_sq_q;
	logic [INV_W-1:0]      inv_radius_sq_q;
	logic [PHI_W-1:0]      ball_threshold_q;
	logic [CNT_THR_W-1:0]  count_threshold_q;
	logic                  wr_en;
	logic [REG_IDX_W-1:0]  reg_idx;
	back_cfg_t             cfg;

	logic                  push, pop, q_empty;
	cand_rec_t             push_rec, pop_rec;
	logic [QCNT_W-1:0]     q_used;

	logic                  dense_out;
	logic [NT_W-1:0]       neighbor_total;
	logic [PHI_W-1:0]      density_sum;

	// register port: zero wait states, write in the access phase
	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign reg_idx = paddr[REG_ADDR_W-1:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rect_mode_q       <= 1'b0;
			radius_sq_q       <= '0;
			inv_radius_sq_q   <= INV_W'(65536);
			ball_threshold_q  <= '0;
			count_threshold_q <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_MODE:      rect_mode_q       <= pwdata[0];
				REG_RADIUS_SQ: radius_sq_q       <= pwdata[ACC_W-1:0];
				REG_INV_RAD:   inv_radius_sq_q   <= pwdata[INV_W-1:0];
				REG_BALL_THR:  ball_threshold_q  <= pwdata[PHI_W-1:0];
				REG_COUNT_THR: count_threshold_q <= pwdata[CNT_THR_W-1:0];
				default:       ;   // unmapped: drop the write
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_MODE:      prdata = REG_DATA_W'(rect_mode_q);
			REG_RADIUS_SQ: prdata = REG_DATA_W'(radius_sq_q);
			REG_INV_RAD:   prdata = REG_DATA_W'(inv_radius_sq_q);
			REG_BALL_THR:  prdata = REG_DATA_W'(ball_threshold_q);
			REG_COUNT_THR: prdata = REG_DATA_W'(count_threshold_q);
			default:       prdata = '0;
		endcase
	end

	assign cfg.rect_mode       = rect_mode_q;
	assign cfg.radius_sq       = radius_sq_q;
	assign cfg.inv_radius_sq   = inv_radius_sq_q;
	assign cfg.ball_threshold  = ball_threshold_q;
	assign cfg.count_threshold = count_threshold_q;

	// front: square and sum each candidate's differences
	sdt_front #(
		.COORD_BITS (COORD_BITS),
		.MAX_DIMS   (MAX_DIMS)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (s_tvalid),
		.in_ready       (s_tready),
		.point_coord    (s_tdata[COORD_BITS-1:0]),
		.cand_coord     (s_tdata[2*COORD_BITS-1:COORD_BITS]),
		.is_self        (s_tuser[0]),
		.last_dim       (s_tuser[1]),
		.last_candidate (s_tlast),
		.queue_used     (q_used),
		.push           (push),
		.push_rec       (push_rec)
	);

	// queue of closed candidates
	sdt_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.pop      (pop),
		.pop_rec  (pop_rec),
		.empty    (q_empty),
		.used     (q_used)
	);

	// back: count neighbours, then form the density and decide
	sdt_back #(
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.rec            (pop_rec),
		.rec_empty      (q_empty),
		.pop            (pop),
		.out_valid      (m_tvalid),
		.out_ready      (m_tready),
		.dense_out      (dense_out),
		.neighbor_total (neighbor_total),
		.density_sum    (density_sum)
	);

	assign m_tdata = {7'd0, density_sum, neighbor_total, dense_out};

endmodule
`default_nettype wire

/* design/sdt_front.sv */
// sdt_front: per-dimension squared difference and per-candidate accumulation.
// Depends on sdt_pkg; pushes one record per closed candidate into sdt_queue.
`default_nettype none
module sdt_front #(
	parameter int COORD_BITS = 16,
	parameter int MAX_DIMS   = 64
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	output logic                         in_ready,
	input  wire signed [COORD_BITS-1:0]  point_coord,
	input  wire signed [COORD_BITS-1:0]  cand_coord,
	input  wire                          is_self,
	input  wire                          last_dim,
	input  wire                          last_candidate,
	input  wire [sdt_pkg::QCNT_W-1:0]    queue_used,
	output logic                         push,
	output sdt_pkg::cand_rec_t           push_rec
);
	import sdt_pkg::*;

	localparam int DIM_W = $clog2(MAX_DIMS + 1);
	localparam int MAG_W = COORD_BITS + 1;

	logic                   accept;
	logic                   close_n;
	logic                   use_n;
	logic [DIM_W-1:0]       dim_q;
	logic signed [MAG_W-1:0] diff;
	logic [MAG_W-1:0]       mag;
	logic [63:0]            mag_ext;

	logic                   vld_s1, use_s1, sat_s1, self_s1, close_s1, last_s1;
	logic [SQ_IN_W-1:0]     mag_s1;
	logic                   vld_s2, self_s2, close_s2, last_s2;
	logic [ACC_W-1:0]       sq_s2;
	logic [ACC_W-1:0]       acc_q;
	logic [ACC_W:0]         acc_sum;
	logic [ACC_W-1:0]       acc_new;
	logic [QCNT_W:0]        credit;

	// hold off input while the queue could not take every candidate in flight
	assign credit = (QCNT_W + 1)'(queue_used) + (QCNT_W + 1)'(vld_s1 & close_s1)
		+ (QCNT_W + 1)'(vld_s2 & close_s2);
	assign in_ready = credit < (QCNT_W + 1)'(QUEUE_DEPTH);
	assign accept   = in_valid & in_ready;
	assign close_n  = last_dim | last_candidate;
	assign use_n    = dim_q < DIM_W'(MAX_DIMS);

	assign diff    = MAG_W'(point_coord) - MAG_W'(cand_coord);
	assign mag     = diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
	assign mag_ext = 64'(mag);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_q <= '0;
		end else if (accept) begin
			if (close_n) begin
				dim_q <= '0;
			end else if (use_n) begin
				dim_q <= dim_q + 1'b1;
			end
		end
	end

	// stage 1: magnitude of the difference
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mag_s1   <= mag_ext[SQ_IN_W-1:0];
			sat_s1   <= mag_ext > SQ_SAT_LIM;
			use_s1   <= use_n;
			self_s1  <= is_self;
			close_s1 <= close_n;
			last_s1  <= last_candidate;
		end
	end

	// stage 2: square, saturated; dimensions past the limit add nothing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			if (!use_s1) begin
				sq_s2 <= '0;
			end else if (sat_s1) begin
				sq_s2 <= '1;
			end else begin
				sq_s2 <= ACC_W'(mag_s1 * mag_s1);
			end
			self_s2  <= self_s1;
			close_s2 <= close_s1;
			last_s2  <= last_s1;
		end
	end

	// accumulate the candidate's distance
	assign acc_sum = {1'b0, acc_q} + {1'b0, sq_s2};
	assign acc_new = acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (vld_s2) begin
			acc_q <= close_s2 ? '0 : acc_new;
		end
	end

	assign push             = vld_s2 & close_s2;
	assign push_rec.dist_sq = acc_new;
	assign push_rec.is_self = self_s2;
	assign push_rec.last    = last_s2;

endmodule
`default_nettype wire

/* design/sdt_queue.sv */
// sdt_queue: short FIFO of closed candidate records between front and back.
// Depends on sdt_pkg for the record type and depth.
`default_nettype none
module sdt_queue (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        push,
	input  sdt_pkg::cand_rec_t         push_rec,
	input  wire                        pop,
	output sdt_pkg::cand_rec_t         pop_rec,
	output logic                       empty,
	output logic [sdt_pkg::QCNT_W-1:0] used
);
	import sdt_pkg::*;

	cand_rec_t         slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] used_q;

	assign pop_rec = slot_q[rd_ptr_q];
	assign empty   = used_q == '0;
	assign used    = used_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			used_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				used_q <= used_q + 1'b1;
			end else if (pop && !push) begin
				used_q <= used_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

/* design/sdt_back.sv */
// sdt_back: radius test, neighbour count and distance total per candidate, then
// the density sum and the decision at the end of a point. Depends on sdt_pkg.
`default_nettype none
module sdt_back #(
	parameter int COUNT_BITS = 16
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  sdt_pkg::back_cfg_t          cfg,
	input  sdt_pkg::cand_rec_t          rec,
	input  wire                         rec_empty,
	output logic                        pop,
	output logic                        out_valid,
	input  wire                         out_ready,
	output logic                        dense_out,
	output logic [sdt_pkg::NT_W-1:0]    neighbor_total,
	output logic [sdt_pkg::PHI_W-1:0]   density_sum
);
	import sdt_pkg::*;

	back_state_t           state_q, state_n;
	logic                  load;
	logic                  hit;
	logic [COUNT_BITS-1:0] count_q;
	logic [TOT_W-1:0]      total_q;
	logic [TOT_W:0]        total_sum;
	logic [PROD_HI_W-1:0]  prod_hi_s1;
	logic [PROD_LO_W-1:0]  prod_lo_s1;
	logic [TERM_W-1:0]     term_s2;
	logic [TERM_W-1:0]     cq;
	logic [TERM_W-1:0]     phi_full;
	logic [PHI_W-1:0]      phi_s3;
	logic [31:0]           count_ext;
	logic                  out_valid_q;

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			B_RUN:   if (!rec_empty && rec.last) state_n = B_MUL;
			B_MUL:   state_n = B_SUM;
			B_SUM:   state_n = B_PHI;
			B_PHI:   state_n = B_LOAD;
			B_LOAD:  if (!out_valid_q || out_ready) state_n = B_RUN;
			default: state_n = B_RUN;
		endcase
	end

	// control outputs
	always_comb begin
		pop  = 1'b0;
		load = 1'b0;
		case (state_q)
			B_RUN:   pop = !rec_empty;
			B_LOAD:  load = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_RUN;
		end else begin
			state_q <= state_n;
		end
	end

	// per-candidate update
	assign hit       = !rec.is_self && (rec.dist_sq <= cfg.radius_sq);
	assign total_sum = {1'b0, total_q} + (TOT_W + 1)'(rec.dist_sq);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			total_q <= '0;
		end else if (load) begin
			count_q <= '0;
			total_q <= '0;
		end else if (pop && hit) begin
			if (count_q != '1) begin
				count_q <= count_q + 1'b1;
			end
			total_q <= total_sum[TOT_W] ? '1 : total_sum[TOT_W-1:0];
		end
	end

	// total * inv_radius_sq in two partial products
	always_ff @(posedge clk) begin
		if (state_q == B_MUL) begin
			prod_hi_s1 <= total_q[TOT_W-1:TOT_SPLIT] * cfg.inv_radius_sq;
			prod_lo_s1 <= total_q[TOT_SPLIT-1:0] * cfg.inv_radius_sq;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == B_SUM) begin
			term_s2 <= TERM_W'(prod_hi_s1) + TERM_W'(prod_lo_s1 >> TOT_SPLIT);
		end
	end

	// phi = count - term, floored at zero, capped at the field width
	assign cq       = TERM_W'(count_q) << 16;
	assign phi_full = (term_s2 >= cq) ? '0 : cq - term_s2;

	always_ff @(posedge clk) begin
		if (state_q == B_PHI) begin
			phi_s3 <= (|phi_full[TERM_W-1:PHI_W]) ? '1 : phi_full[PHI_W-1:0];
		end
	end

	// output register
	assign count_ext = 32'(count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			dense_out      <= cfg.rect_mode ? (count_ext >= 32'(cfg.count_threshold))
				: (phi_s3 >= cfg.ball_threshold);
			neighbor_total <= (|count_ext[31:NT_W]) ? '1 : count_ext[NT_W-1:0];
			density_sum    <= phi_s3;
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// tb_top: self-checking bench for subspace_density_test with its own predictor.
// Depends on sdt_pkg and the design files under design/.
`default_nettype none
module tb_top;
	import sdt_pkg::*;

	localparam int          CLK_PERIOD  = 10;
	localparam int          STALL_LIMIT = 2000;    // cycles with no handshake and no register access
	localparam int          MAX_DIMS    = 64;
	localparam logic [63:0] ACC_MAX     = (64'd1 << ACC_W) - 64'd1;
	localparam logic [63:0] TOT_MAX     = (64'd1 << TOT_W) - 64'd1;
	localparam logic [63:0] CNT_MAX     = 64'hFFFF;
	localparam logic [63:0] LO_MASK     = (64'd1 << TOT_SPLIT) - 64'd1;

	// one decision as it leaves the block
	typedef struct {
		logic        dense;
		logic [15:0] total;
		logic [31:0] phi;
	} decision_t;

	// Tracks the point under test and holds the decisions still owed by the block.
	class density_predictor;
		logic        rect_mode;
		logic [63:0] radius_sq;
		logic [63:0] inv_radius_sq;
		logic [63:0] ball_thr;
		logic [63:0] count_thr;
		logic [63:0] cand_dist;
		logic [63:0] nbr_count;
		logic [63:0] nbr_dist_total;
		int          dims_seen;
		decision_t   due_decisions[$];
		int          mismatches;

		function new();
			rect_mode      = 1'b0;
			radius_sq      = '0;
			inv_radius_sq  = 64'd65536;
			ball_thr       = '0;
			count_thr      = '0;
			cand_dist      = '0;
			nbr_count      = '0;
			nbr_dist_total = '0;
			dims_seen      = 0;
			mismatches     = 0;
		endfunction

		function void set_reg(logic [REG_IDX_W-1:0] idx, logic [63:0] value);
			case (idx)
				REG_MODE:      rect_mode     = value[0];
				REG_RADIUS_SQ: radius_sq     = value & ACC_MAX;
				REG_INV_RAD:   inv_radius_sq = {32'd0, value[31:0]};
				REG_BALL_THR:  ball_thr      = {32'd0, value[31:0]};
				REG_COUNT_THR: count_thr     = {48'd0, value[15:0]};
				default: ;
			endcase
		endfunction

		function void absorb_dimension(logic [15:0] pc, logic [15:0] cc, bit self_flag,
				bit ld, bit lc);
			logic signed [16:0] diff;
			logic [16:0]        mag;
			logic [63:0]        sq, sum, hi, lo, term, cq, phi;
			decision_t          d;
			diff = $signed(pc) - $signed(cc);
			mag  = diff[16] ? 17'(-diff) : 17'(diff);
			if (dims_seen < MAX_DIMS) begin
				sq  = (64'(mag) > SQ_SAT_LIM) ? ACC_MAX : 64'(mag) * 64'(mag);
				sum = cand_dist + sq;
				cand_dist = (sum > ACC_MAX) ? ACC_MAX : sum;
				dims_seen++;
			end
			// the self flag only counts on the beat that closes the candidate
			if (ld || lc) begin
				if (!self_flag && cand_dist <= radius_sq) begin
					if (nbr_count < CNT_MAX)
						nbr_count++;
					sum = nbr_dist_total + cand_dist;
					nbr_dist_total = (sum > TOT_MAX) ? TOT_MAX : sum;
				end
				cand_dist = '0;
				dims_seen = 0;
			end
			if (!lc)
				return;
			hi   = nbr_dist_total >> TOT_SPLIT;
			lo   = nbr_dist_total & LO_MASK;
			term = hi * inv_radius_sq + ((lo * inv_radius_sq) >> TOT_SPLIT);
			cq   = nbr_count << 16;
			phi  = (term >= cq) ? 64'd0 : cq - term;
			d.dense = rect_mode ? (nbr_count >= count_thr) : (phi >= ball_thr);
			d.total = (nbr_count > 64'hFFFF) ? 16'hFFFF : nbr_count[15:0];
			d.phi   = (phi > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : phi[31:0];
			due_decisions = {due_decisions, d};
			cand_dist      = '0;
			nbr_count      = '0;
			nbr_dist_total = '0;
			dims_seen      = 0;
		endfunction

		function void check_decision(logic [55:0] word);
			decision_t want;
			if (due_decisions.size() == 0) begin
				$display("%0t: decision with none outstanding, tdata %h", $time, word);
				mismatches++;
				return;
			end
			want = due_decisions.pop_front();
			if (word[0] !== want.dense) begin
				$display("%0t: dense flag expected %0d actual %0d", $time, want.dense, word[0]);
				mismatches++;
			end
			if (word[16:1] !== want.total) begin
				$display("%0t: neighbor_total expected %0d actual %0d", $time, want.total,
					word[16:1]);
				mismatches++;
			end
			if (word[48:17] !== want.phi) begin
				$display("%0t: density_sum expected %h actual %h", $time, want.phi,
					word[48:17]);
				mismatches++;
			end
		endfunction
	endclass

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [31:0]           s_tdata  = '0;    // [15:0] point_coord, [31:16] cand_coord
	logic [1:0]            s_tuser  = '0;    // [0] is_self, [1] last_dim
	logic                  s_tlast  = 1'b0;  // last_candidate
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [55:0]           m_tdata;          // [0] dense flag, [16:1] total, [48:17] phi
	logic                  psel     = 1'b0;
	logic                  penable  = 1'b0;
	logic                  pwrite   = 1'b0;
	logic [REG_ADDR_W-1:0] paddr    = '0;
	logic [REG_DATA_W-1:0] pwdata   = '0;
	logic [REG_DATA_W-1:0] prdata;
	logic                  pready;

	density_predictor board = new();
	int src_idle_pct  = 24;
	int sink_idle_pct = 47;
	int stall_cycles  = 0;

	subspace_density_test dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Receiver: check every decision beat, then pick the next cycle's ready at random.
	// Values read here are the ones from before the edge, as all drives are nonblocking.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_decision(m_tdata);
		m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
	end

	// Watchdog: give up once nothing has moved on any port for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Present one dimension beat, idling at random first, and hold it until taken.
	// tvalid is left high on return so that back-to-back beats never drop it.
	task automatic send_beat(input logic [15:0] pc, input logic [15:0] cc,
			input bit self_flag, input bit ld, input bit lc);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {cc, pc};
		s_tuser  <= {ld, self_flag};
		s_tlast  <= lc;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		board.absorb_dimension(pc, cc, self_flag, ld, lc);
	endtask

	// Drop tvalid and hold off until every owed decision has come back, then idle on.
	task automatic drain(input int extra);
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (board.due_decisions.size() != 0);
		repeat (extra) @(posedge clk);
	endtask

	// One register write: setup cycle, then access cycle; psel stays up for the next.
	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [63:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		board.set_reg(idx, value);
	endtask

	// Rewrite the whole register set; only ever called with the block drained.
	task automatic apply_settings(input bit mode, input logic [63:0] radius,
			input logic [63:0] inv, input logic [63:0] ball, input logic [63:0] cnt);
		write_reg(REG_MODE, {63'd0, mode});
		write_reg(REG_RADIUS_SQ, radius);
		write_reg(REG_INV_RAD, inv);
		write_reg(REG_BALL_THR, ball);
		write_reg(REG_COUNT_THR, cnt);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Pick a register set: all-ones and all-zero on two segments, random elsewhere.
	task automatic choose_settings(input int seg);
		logic [63:0] radius, inv, ball, cnt;
		if (seg == 1) begin
			apply_settings(1'b0, ACC_MAX, 64'hFFFF_FFFF, 64'hFFFF_FFFF, 64'hFFFF);
			return;
		end
		if (seg == 5) begin
			apply_settings(1'b1, 64'd0, 64'd0, 64'd0, 64'd0);
			return;
		end
		case ($urandom_range(0, 5))
			0:       radius = '0;
			1:       radius = ACC_MAX;
			default: radius = ({$urandom, $urandom} & ACC_MAX) >> $urandom_range(0, 37);
		endcase
		case ($urandom_range(0, 4))
			0:       inv = '0;
			1:       inv = 64'hFFFF_FFFF;
			2:       inv = 64'd65536;
			default: inv = 64'($urandom >> $urandom_range(0, 31));
		endcase
		case ($urandom_range(0, 4))
			0:       ball = '0;
			1:       ball = 64'hFFFF_FFFF;
			2:       ball = 64'($urandom);
			default: ball = (64'($urandom_range(0, 8)) << 16) + 64'($urandom_range(0, 65535));
		endcase
		case ($urandom_range(0, 4))
			0:       cnt = '0;
			1:       cnt = 64'hFFFF;
			2:       cnt = 64'($urandom & 16'hFFFF);
			default: cnt = 64'($urandom_range(0, 10));
		endcase
		apply_settings(1'(seg % 2), radius, inv, ball, cnt);
	endtask

	// One point: a run of candidates around a fixed home position, closed by tlast.
	// Most points are well formed; a tenth get ragged last_dim flags as noise.
	task automatic send_point(output int sent);
		logic [15:0] home [0:71];
		logic [15:0] off, cc;
		int          n_cand, n_dims, shape, reach, c, d;
		bit          self_c, ld, lc, ragged, neg;
		sent   = 0;
		ragged = ($urandom_range(0, 9) == 0);
		for (d = 0; d < 72; d++)
			home[d] = ($urandom_range(0, 6) == 0) ?
				($urandom_range(0, 1) ? 16'h8000 : 16'h7FFF) : 16'($urandom);
		n_cand = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 6) : $urandom_range(1, 20);
		for (c = 0; c < n_cand; c++) begin
			// now and then run past the dimension limit
			n_dims = ($urandom_range(0, 29) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 5);
			shape  = $urandom_range(0, 5);
			reach  = $urandom_range(0, 15);
			self_c = ($urandom_range(0, 9) == 0);
			for (d = 0; d < n_dims; d++) begin
				neg = $urandom_range(0, 1);
				case (shape)
					0:       off = '0;
					1:       off = 16'($urandom);
					default: off = 16'($urandom_range(0, (1 << reach) - 1));
				endcase
				cc = neg ? home[d] - off : home[d] + off;
				// far corner: the widest difference a dimension can give
				if (shape == 2)
					cc = home[d][15] ? 16'h7FFF : 16'h8000;
				lc = (c == n_cand - 1) && (d == n_dims - 1);
				ld = (d == n_dims - 1) && !(lc && $urandom_range(0, 4) == 0);
				if (ragged && !lc)
					ld = ($urandom_range(0, 3) == 0);
				send_beat(home[d], cc, (d == n_dims - 1) ? self_c : bit'($urandom_range(0, 1)),
					ld, lc);
				sent++;
			end
		end
	endtask

	initial begin
		int phase, k, seg, sent, budget;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, reset settings (radius zero): a zero distance still counts.
		send_beat(16'h1234, 16'h1234, 1'b0, 1'b1, 1'b0);
		send_beat(16'h8000, 16'h7FFF, 1'b0, 1'b1, 1'b0);
		send_beat(16'h7FFF, 16'h8000, 1'b0, 1'b0, 1'b0);
		send_beat(16'h7FFF, 16'h8000, 1'b1, 1'b1, 1'b0);   // self on the closing beat
		send_beat(16'h0005, 16'h0005, 1'b1, 1'b0, 1'b0);   // self mid-candidate: ignored
		send_beat(16'h0005, 16'h0005, 1'b0, 1'b1, 1'b0);
		send_beat(16'h0000, 16'h0000, 1'b0, 1'b0, 1'b1);   // closes without last_dim
		send_beat(16'h4321, 16'h4321, 1'b1, 1'b1, 1'b1);   // point of only itself
		drain(20);

		// Radius equal to the distance counts; phi equal to the threshold passes.
		apply_settings(1'b0, 64'd180000, 64'd65536, 64'd131062, 64'd0);
		for (k = 0; k < 2; k++) begin
			send_beat(16'd0, 16'd300, 1'b0, 1'b0, 1'b0);
			send_beat(16'd0, -16'sd300, 1'b0, 1'b1, 1'b0);
			send_beat(16'd0, 16'd300, 1'b0, 1'b0, 1'b0);
			send_beat(16'd0, 16'd301, 1'b0, 1'b1, 1'b0);
			send_beat(16'd7, 16'd7, 1'b0, 1'b1, 1'b1);
			drain(20);
			// rerun with the count test, threshold just out of reach
			if (k == 0)
				apply_settings(1'b1, 64'd180000, 64'd65536, 64'd131062, 64'd3);
		end

		// Random points in three idling regimes, a fresh register set per segment.
		for (phase = 0; phase < 3; phase++) begin
			src_idle_pct  <= (phase == 0) ? 24 : (phase == 1) ? 47 : 0;
			sink_idle_pct <= (phase == 0) ? 47 : (phase == 1) ? 24 : 0;
			for (k = 0; k < 4; k++) begin
				seg    = phase * 4 + k;
				budget = 0;
				choose_settings(seg);
				while (budget < 40) begin
					send_point(sent);
					budget += sent;
					// hold the sender off now and then until the output side catches up
					if ($urandom_range(0, 19) == 0)
						drain(0);
				end
				drain(20);
			end
		end

		// Let the tail clear, then report.
		drain(30);
		if (board.mismatches == 0 && board.due_decisions.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
`default_nettype wire
